FILE: design/box_filter_detrend_top_macros.svh
// assertion macros shared by the box filter detrend design files
`ifndef BOX_FILTER_DETREND_TOP_MACROS_SVH
`define BOX_FILTER_DETREND_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define BFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define BFD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/bfd_pkg.sv
// shared types and constants of the box filter detrend block
`default_nettype none

package bfd_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_BITS = 17;

    // default filter shape
    localparam int DEF_LEFT_TAPS  = 3;
    localparam int DEF_RIGHT_TAPS = 3;
    localparam int DEF_DIVISOR    = 7;

    // largest tap count supported on one side, and the count width it needs
    localparam int MAX_TAPS     = 15;
    localparam int TAP_CNT_BITS = $clog2(MAX_TAPS + 2);

    // depth of the command queue and of the result queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] result;
        logic                          last_res;
    } out_item_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic                          emit;
        logic [TAP_CNT_BITS-1:0]       total;
    } cmd_t;

    typedef enum logic {
        SEQ_RUN,
        SEQ_FLUSH
    } seq_state_t;

endpackage

`default_nettype wire

FILE: design/bfd_fifo.sv
// small first-in first-out queue with show-ahead output
`default_nettype none

`include "box_filter_detrend_top_macros.svh"

module bfd_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = bfd_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      din,
    output logic                       full,
    input  logic                       pop,
    output item_t                      dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import bfd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    item_t               mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    // transfer qualification
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // status and head of queue
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign dout  = mem_reg[rd_ptr_reg];

    `BFD_NEVER(a_fifo_overflow, push && full && (DEPTH == 0), "queue depth is zero")
    `BFD_ASSERT(a_fifo_level, count_reg <= FULL_CNT, "queue fill level beyond depth")

endmodule

`default_nettype wire

FILE: design/bfd_front.sv
// front end: accepts samples and classifies them by position in the sequence
`default_nettype none

module bfd_front #(
    parameter int RIGHT_TAPS = bfd_pkg::DEF_RIGHT_TAPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  bfd_pkg::in_item_t item,
    input  logic             q_full,
    output logic             cmd_push,
    output bfd_pkg::cmd_t    cmd
);
    import bfd_pkg::*;

    localparam logic [TAP_CNT_BITS-1:0] SAT_CNT = TAP_CNT_BITS'(RIGHT_TAPS + 1);
    localparam logic [TAP_CNT_BITS-1:0] R_CNT   = TAP_CNT_BITS'(RIGHT_TAPS);

    logic [TAP_CNT_BITS-1:0] seen_reg, seen_next;
    logic [TAP_CNT_BITS-1:0] total;
    logic                    take;

    // input transfer happens while the command queue has room
    assign full     = q_full;
    assign take     = push && !q_full;
    assign cmd_push = take;

    // samples seen so far including this one, saturating
    assign total = (seen_reg == SAT_CNT) ? seen_reg : seen_reg + 1'b1;

    // classification of the sample
    always_comb
    begin
        cmd.sample = item.sample;
        cmd.last   = item.last;
        cmd.total  = total;
        cmd.emit   = (total > R_CNT);
    end

    // sequence position tracking, cleared by the last sample
    always_comb
    begin
        seen_next = seen_reg;
        if (take)
        begin
            seen_next = item.last ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bfd_back.sv
// back end: sample line, window sum, divide by constant and subtraction
`default_nettype none

`include "box_filter_detrend_top_macros.svh"

module bfd_back #(
    parameter int LEFT_TAPS  = bfd_pkg::DEF_LEFT_TAPS,
    parameter int RIGHT_TAPS = bfd_pkg::DEF_RIGHT_TAPS,
    parameter int DIVISOR    = bfd_pkg::DEF_DIVISOR,
    parameter int OUT_DEPTH  = bfd_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  bfd_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output bfd_pkg::out_item_t             res
);
    import bfd_pkg::*;

    localparam int LINE_DEPTH = LEFT_TAPS + RIGHT_TAPS + 1;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(LINE_DEPTH);
    localparam int MAG_BITS   = SUM_BITS;
    localparam int DIV_LOG    = $clog2(DIVISOR);
    localparam int DIV_SHIFT  = MAG_BITS + DIV_LOG;
    localparam int RECIP_BITS = MAG_BITS + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
    localparam int LO_BITS    = (MAG_BITS + 1) / 2;
    localparam int HI_BITS    = MAG_BITS - LO_BITS;
    localparam int PLO_BITS   = LO_BITS + RECIP_BITS;
    localparam int PHI_BITS   = HI_BITS + RECIP_BITS;
    localparam int FULL_BITS  = MAG_BITS + RECIP_BITS + 1;
    localparam int DIFF_BITS  = (MAG_BITS + 2 > RESULT_BITS) ? MAG_BITS + 2 : RESULT_BITS;
    localparam int CNT_BITS   = $clog2(OUT_DEPTH + 1);
    localparam int FLUSH_BITS = $clog2(RIGHT_TAPS + 1);
    localparam logic [FLUSH_BITS-1:0]   FLUSH_END = FLUSH_BITS'(RIGHT_TAPS);
    localparam logic [TAP_CNT_BITS:0]   R_WIDE    = (TAP_CNT_BITS+1)'(RIGHT_TAPS);
    localparam logic [CNT_BITS:0]       OUT_CAP   = (CNT_BITS+1)'(OUT_DEPTH);

    // sequencer
    seq_state_t              state_reg, state_next;
    logic [FLUSH_BITS-1:0]   flush_k_reg, flush_k_next;
    logic [TAP_CNT_BITS-1:0] total_reg, total_next;
    logic                    clear_reg, clear_next;
    logic                    credit_ok;
    logic                    issue;
    logic signed [SAMPLE_BITS-1:0] op_val;
    logic                    op_emit;
    logic                    op_last;

    // sample line
    logic signed [SAMPLE_BITS-1:0] line_reg  [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] line_next [LINE_DEPTH];

    // window sum stage
    logic                          v1_reg;
    logic                          l1_reg;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SAMPLE_BITS-1:0] ctr1_reg;

    // partial product stage
    logic                          v2_reg;
    logic                          l2_reg;
    logic                          neg2_reg;
    logic signed [SAMPLE_BITS-1:0] ctr2_reg;
    logic [MAG_BITS-1:0]           mag;
    logic [PLO_BITS-1:0]           p_lo_reg;
    logic [PHI_BITS-1:0]           p_hi_reg;

    // combine stage
    logic [FULL_BITS-1:0]          prod_full;
    logic [MAG_BITS-1:0]           quot;
    logic signed [DIFF_BITS-1:0]   quot_s;
    logic signed [DIFF_BITS-1:0]   diff;

    // room in the result queue for everything already under way
    assign credit_ok = ((CNT_BITS+1)'(out_count) + (CNT_BITS+1)'(v1_reg)
                        + (CNT_BITS+1)'(v2_reg)) < OUT_CAP;

    // sequencer outputs
    always_comb
    begin
        issue   = 1'b0;
        cmd_pop = 1'b0;
        op_val  = '0;
        op_emit = 1'b0;
        op_last = 1'b0;
        unique case (state_reg)
            SEQ_RUN:
            begin
                if (cmd_valid && credit_ok)
                begin
                    issue   = 1'b1;
                    cmd_pop = 1'b1;
                    op_val  = cmd.sample;
                    op_emit = cmd.emit;
                end
            end
            SEQ_FLUSH:
            begin
                if (credit_ok)
                begin
                    issue   = 1'b1;
                    op_emit = ((TAP_CNT_BITS+1)'(total_reg)
                               + (TAP_CNT_BITS+1)'(flush_k_reg)) > R_WIDE;
                    op_last = (flush_k_reg == FLUSH_END);
                end
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        flush_k_next = flush_k_reg;
        total_next   = total_reg;
        clear_next   = clear_reg;
        unique case (state_reg)
            SEQ_RUN:
            begin
                if (issue)
                begin
                    clear_next = 1'b0;
                    if (cmd.last)
                    begin
                        state_next   = SEQ_FLUSH;
                        flush_k_next = FLUSH_BITS'(1);
                        total_next   = cmd.total;
                    end
                end
            end
            SEQ_FLUSH:
            begin
                if (issue)
                begin
                    if (flush_k_reg == FLUSH_END)
                    begin
                        state_next = SEQ_RUN;
                        clear_next = 1'b1;
                    end
                    else
                    begin
                        flush_k_next = flush_k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_RUN;
            flush_k_reg <= '0;
            total_reg   <= '0;
            clear_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            flush_k_reg <= flush_k_next;
            total_reg   <= total_next;
            clear_reg   <= clear_next;
        end
    end

    // shift line, emptied first when a sequence has just ended
    always_comb
    begin
        line_next[0] = op_val;
        for (int i = 1; i < LINE_DEPTH; i++)
        begin
            line_next[i] = clear_reg ? '0 : line_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (issue)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_reg[i] <= line_next[i];
            end
        end
    end

    // window sum over the line as it stands after this operation
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            sum_next = sum_next + SUM_BITS'(line_next[i]);
        end
    end

    // pipeline valid flags, only result-bearing operations travel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue && op_emit;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg   <= op_last;
        sum_reg  <= sum_next;
        ctr1_reg <= line_next[RIGHT_TAPS];
    end

    // magnitude times reciprocal, split in two partial products
    assign mag = sum_reg[SUM_BITS-1] ? MAG_BITS'(-sum_reg) : MAG_BITS'(sum_reg);

    always_ff @(posedge clk)
    begin
        l2_reg   <= l1_reg;
        neg2_reg <= sum_reg[SUM_BITS-1];
        ctr2_reg <= ctr1_reg;
        p_lo_reg <= PLO_BITS'(mag[LO_BITS-1:0]) * PLO_BITS'(RECIP);
        p_hi_reg <= PHI_BITS'(mag[MAG_BITS-1:LO_BITS]) * PHI_BITS'(RECIP);
    end

    // quotient truncated toward zero, then subtracted from the centre sample
    assign prod_full = (FULL_BITS'(p_hi_reg) << LO_BITS) + FULL_BITS'(p_lo_reg);
    assign quot      = MAG_BITS'(prod_full >> DIV_SHIFT);
    assign quot_s    = neg2_reg ? -DIFF_BITS'(quot) : DIFF_BITS'(quot);
    assign diff      = DIFF_BITS'(ctr2_reg) - quot_s;

    assign res_push     = v2_reg;
    assign res.result   = diff[RESULT_BITS-1:0];
    assign res.last_res = l2_reg;

    `BFD_ASSERT(a_back_credit,
        ((CNT_BITS+1)'(out_count) + (CNT_BITS+1)'(v1_reg) + (CNT_BITS+1)'(v2_reg)) <= OUT_CAP,
        "results under way exceed result queue room")
    `BFD_ASSERT(a_back_flush_idx,
        (state_reg == SEQ_FLUSH) |-> (flush_k_reg != '0),
        "flush step index zero while flushing")
    `BFD_ASSERT(a_back_clear_after_flush,
        (issue && op_last) |=> (clear_reg && state_reg == SEQ_RUN),
        "line not marked for clearing after the final flush step")

endmodule

`default_nettype wire

FILE: design/box_filter_detrend_top.sv
// top level of the box filter detrend block
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  samples  | push / full        | sample_item (sample, last)
//  results  | pop / empty        | result_item (result, last_res)
//
// Samples are taken one per cycle while the command queue has room; a last
// sample holds the back end for its own slot, then one zero shift per flush step.
// A result reaches the result ports after its operation issues, through the
// registered steps of line update with window sum, partial products and result queue write.
// Reset clears the line and sequence position; no clearing pass is needed.
// A stalled result side fills the result queue, then the command queue, then
// raises full.
`default_nettype none

module box_filter_detrend_top #(
    parameter int LEFT_TAPS  = bfd_pkg::DEF_LEFT_TAPS,
    parameter int RIGHT_TAPS = bfd_pkg::DEF_RIGHT_TAPS,
    parameter int DIVISOR    = bfd_pkg::DEF_DIVISOR
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bfd_pkg::in_item_t  sample_item,
    output logic               empty,
    input  logic               pop,
    output bfd_pkg::out_item_t result_item
);
    import bfd_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic                cmd_push;
    cmd_t                cmd_in;
    logic                cmd_full;
    cmd_t                cmd_out;
    logic                cmd_empty;
    logic                cmd_pop;
    logic [CNT_BITS-1:0] cmd_count;
    logic                res_push;
    out_item_t           res;
    logic                res_full;
    logic [CNT_BITS-1:0] res_count;

    // sample intake and classification
    bfd_front #(
        .RIGHT_TAPS (RIGHT_TAPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (sample_item),
        .q_full   (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // queue between front and back
    bfd_fifo #(
        .item_t (cmd_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    // filter datapath
    bfd_back #(
        .LEFT_TAPS  (LEFT_TAPS),
        .RIGHT_TAPS (RIGHT_TAPS),
        .DIVISOR    (DIVISOR),
        .OUT_DEPTH  (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_count (res_count),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue feeding the output side
    bfd_fifo #(
        .item_t (out_item_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (result_item),
        .empty (empty),
        .count (res_count)
    );

    `include "box_filter_detrend_top_macros.svh"

    `BFD_NEVER(a_top_res_overflow, res_push && res_full,
        "result transfer into a full result queue")
    `BFD_ASSERT(a_top_cmd_level, cmd_count <= CNT_BITS'(QUEUE_DEPTH),
        "command queue level beyond depth")

endmodule

`default_nettype wire

FILE: tb/sv/box_filter_detrend_top_test.sv
// self-checking testbench for the box filter detrend block
module box_filter_detrend_top_test;

    localparam int TAPS_BEFORE = bfd_pkg::DEF_LEFT_TAPS;
    localparam int TAPS_AFTER  = bfd_pkg::DEF_RIGHT_TAPS;
    localparam int WINDOW_DIV  = bfd_pkg::DEF_DIVISOR;
    localparam int WINDOW_LEN  = TAPS_BEFORE + TAPS_AFTER + 1;
    localparam int RANDOM_ITEMS = 340;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum int {
        POP_ALWAYS,
        POP_HALF,
        POP_RARE,
        POP_CADENCE,
        POP_HOLD
    } pop_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    bfd_pkg::in_item_t sample_item = '0;
    logic full;
    logic empty;
    bfd_pkg::out_item_t result_item;

    // predictor state
    logic signed [15:0] window_taps [WINDOW_LEN];
    int taps_seen = 0;
    bfd_pkg::out_item_t expected_results [$];

    int errors = 0;
    int cycle_count = 0;
    int samples_sent = 0;
    int burst_left = 0;
    logic drain_all = 1'b0;
    pop_mode_t pop_mode = POP_ALWAYS;
    int pop_mode_left = 0;
    int pop_phase = 0;

    box_filter_detrend_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

    always #10 clk = ~clk;

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("box_filter_detrend_top_test: FAIL");
            $finish;
        end
    end

    // window line shift, newest sample at entry 0
    function automatic void shift_window(input logic signed [15:0] v);
        for (int k = WINDOW_LEN - 1; k > 0; k--)
            window_taps[k] = window_taps[k - 1];
        window_taps[0] = v;
    endfunction

    // centre sample minus truncated window mean
    function automatic logic signed [16:0] detrended_centre();
        int sum;
        int quo;
        int diff;
        sum = 0;
        for (int k = 0; k < WINDOW_LEN; k++)
            sum += window_taps[k];
        quo = sum / WINDOW_DIV;
        diff = window_taps[TAPS_AFTER] - quo;
        return diff[16:0];
    endfunction

    function automatic void clear_window();
        for (int k = 0; k < WINDOW_LEN; k++)
            window_taps[k] = '0;
        taps_seen = 0;
    endfunction

    function automatic void queue_result(input logic signed [16:0] r, input logic l);
        bfd_pkg::out_item_t item;
        item.result = r;
        item.last_res = l;
        expected_results.push_back(item);
    endfunction

    // expected results caused by one accepted sample
    function automatic void predict_detrend(input logic signed [15:0] s, input logic l);
        int total;
        shift_window(s);
        total = taps_seen + 1;
        if (total > TAPS_AFTER + 1)
            total = TAPS_AFTER + 1;
        taps_seen = total;
        if (total > TAPS_AFTER)
            queue_result(detrended_centre(), l && TAPS_AFTER == 0);
        if (l)
        begin
            // flush pending positions with zeros
            for (int k = 1; k <= TAPS_AFTER; k++)
            begin
                shift_window('0);
                if (total + k > TAPS_AFTER)
                    queue_result(detrended_centre(), k == TAPS_AFTER);
            end
            clear_window();
        end
    endfunction

    // one sample transfer; returns in the step of acceptance with push still high
    task automatic send_sample(input logic signed [15:0] s, input logic l);
        push <= 1'b1;
        sample_item <= '{sample: s, last: l};
        do
            @(posedge clk);
        while (full);
        predict_detrend(s, l);
        samples_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // result check and receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %0d last %0b",
                             $time, $signed(result_item.result), result_item.last_res);
                end
                else
                begin
                    bfd_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    if (result_item.result !== want.result)
                    begin
                        errors++;
                        $display("%0t: result mismatch: expected %0d, actual %0d", $time,
                                 $signed(want.result), $signed(result_item.result));
                    end
                    if (result_item.last_res !== want.last_res)
                    begin
                        errors++;
                        $display("%0t: last_res mismatch: expected %0b, actual %0b", $time,
                                 want.last_res, result_item.last_res);
                    end
                end
            end

            // pick a new stall mode now and then
            if (pop_mode_left == 0)
            begin
                pop_mode <= pop_mode_t'($urandom_range(0, 4));
                pop_mode_left <= $urandom_range(5, 60);
            end
            else
            begin
                pop_mode_left <= pop_mode_left - 1;
            end
            pop_phase <= pop_phase + 1;

            if (drain_all)
                pop <= 1'b1;
            else
                case (pop_mode)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_HALF:    pop <= 1'($urandom_range(0, 1));
                    POP_RARE:    pop <= ($urandom_range(0, 3) == 0);
                    POP_CADENCE: pop <= (pop_phase % 5) != 0;
                    default:     pop <= 1'b0;
                endcase
        end
    end

    // random sample value, weighted toward the extremes
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] v;
        int sel;
        sel = $urandom_range(0, 19);
        v = 16'($urandom());
        case (sel)
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = 16'(int'($urandom_range(0, 20)) - 10);
            default: ;
        endcase
        return v;
    endfunction

    // single-sample sequences at the extremes and around zero
    task automatic test_single_sample();
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b1);
    endtask

    // short sequences of two to four samples
    task automatic test_short_sequences();
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd7, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(16'sd5, 1'b1);
        for (int k = 1; k <= 4; k++)
            send_sample(16'(k), k == 4);
    endtask

    // a full window of the largest sample, then a shorter run of the smallest
    task automatic test_saturated_windows();
        for (int k = 0; k < 7; k++)
            send_sample(SAMPLE_MAX, k == 6);
        idle_cycles(3);
        for (int k = 0; k < 5; k++)
            send_sample(SAMPLE_MIN, k == 4);
    endtask

    // random sequences with bursty sender
    task automatic test_random_sequences();
        int seq_len;
        int sel;
        int first_sent;
        logic gapless;
        logic same_value;
        logic signed [15:0] fill;
        logic paused;
        first_sent = samples_sent;
        paused = 1'b0;
        while (samples_sent - first_sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                seq_len = $urandom_range(1, 12);
            else if (sel < 19)
                seq_len = $urandom_range(13, 40);
            else
                seq_len = $urandom_range(41, 80);
            same_value = ($urandom_range(0, 9) == 0);
            fill = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            for (int k = 0; k < seq_len; k++)
            begin
                gapless = (((samples_sent - first_sent) / 60) % 3) == 1;
                if (burst_left == 0)
                begin
                    if (!gapless)
                        idle_cycles($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                send_sample(same_value ? fill : pick_sample(), k == seq_len - 1);
            end
            // one full drain midway through
            if (!paused && samples_sent - first_sent > RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        clear_window();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample();
        test_short_sequences();
        test_saturated_windows();
        wait_drained();
        test_random_sequences();

        // let everything come back
        push <= 1'b0;
        drain_all <= 1'b1;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("box_filter_detrend_top_test: PASS");
        else
            $display("box_filter_detrend_top_test: FAIL");
        $finish;
    end

endmodule
